FILE: sv/pwlw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlw_pkg: shared types and constants of the protobuf wire length walker
// Stop reason codes, varint accumulator widths and the result record.
// ----------------------------------------------------------------------------
package pwlw_pkg;

  // Default bound on buffer length in bytes.
  localparam int unsigned MAX_BYTES_DEFAULT = 262144;

  // Reset value of the field number limit register.
  localparam logic [31:0] MAX_FIELD_RESET = 32'd100000;

  // The accumulator keeps tag bits 34..0; anything above only matters as a
  // sticky "large" flag for lengths.
  localparam int unsigned ACC_W = 35;

  // Varint byte counter; index nine is the tenth and final permitted byte.
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] VARINT_LAST_IDX = 4'd9;

  localparam int unsigned SIZE_W = 19;

  typedef enum logic [2:0] {
    STOP_NONE        = 3'd0,
    STOP_TRUNCATED   = 3'd1,
    STOP_ZERO_FIELD  = 3'd2,
    STOP_OVER_LIMIT  = 3'd3,
    STOP_BAD_WIRE    = 3'd4,
    STOP_VARINT_LONG = 3'd5
  } stop_e;

  typedef struct packed {
    logic [SIZE_W-1:0] measured_size;
    logic              clean_end;
    stop_e             stop_reason;
  } result_t;

endpackage

FILE: sv/pwlw_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlw_in_if: byte stream channel
// Valid/ready channel carrying one buffer byte and its last marker.
// ----------------------------------------------------------------------------
interface pwlw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

FILE: sv/pwlw_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlw_out_if: result channel
// Valid/ready channel carrying the measured size and the stop reason.
// ----------------------------------------------------------------------------
interface pwlw_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] measured_size;
  logic        clean_end;
  logic [2:0]  stop_reason;

  modport source (output valid, output measured_size, output clean_end,
                  output stop_reason, input ready);
  modport sink   (input valid, input measured_size, input clean_end,
                  input stop_reason, output ready);
endinterface

FILE: sv/protobuf_wire_length_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_wire_length_walker: streaming protobuf wire format field skipper
// Walks tags and values of one buffer byte by byte and reports, on the last
// byte, the offset after the last complete field and why the walk stopped.
// ----------------------------------------------------------------------------
//
//  Channel  Port         Direction  Payload
//  -------  -----------  ---------  ------------------------------------------
//  bytes    in_i         sink       data_byte[7:0], is_last
//  results  out_o        source     measured_size[18:0], clean_end,
//                                   stop_reason[2:0]
//  config   cfg_we_i,    write      max_field_number[31:0]
//           cfg_wdata_i
//
// One byte is taken per cycle: the walker state registers are updated by a
// single pass of combinational logic (varint merge, tag decode, one counter
// compare), so the byte rate is set only by the result register's space.
// The result is offered on the result channel in the cycle after the transaction
// that carried the last byte.
// The input stalls only while a result is held and the sink is not ready.
// Reset clears the walk state and loads the field limit with 100000; no
// clearing pass is needed.
//
module protobuf_wire_length_walker
  import pwlw_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  pwlw_in_if.sink     in_i,
  pwlw_out_if.source  out_o
);

  // Position counters saturate at MAX_BYTES, so they must hold it.
  localparam int unsigned POS_W = $clog2(MAX_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BYTES);
  localparam logic [ACC_W-1:0] LEN_MAX = ACC_W'(MAX_BYTES);
  localparam logic [POS_W-1:0] SKIP_FIXED64 = POS_W'(8);
  localparam logic [POS_W-1:0] SKIP_FIXED32 = POS_W'(4);

  // Walker phases.
  localparam logic [1:0] PH_TAG    = 2'd0;
  localparam logic [1:0] PH_VALUE  = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  // Wire types that the walker can skip.
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH  = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Walker state registers.
  logic [31:0]      max_field_q;
  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             hi_q, hi_d;
  logic [POS_W-1:0] skip_q, skip_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] bound_q, bound_d;
  stop_e            stop_q, stop_d;

  logic             in_fire;
  logic             space;
  logic             load_result;
  result_t          result;
  stop_e            reason;

  // Varint merge of the incoming byte.
  logic [ACC_W-1:0] vi_acc;
  logic             vi_hi;
  logic             vi_more;
  logic             vi_too_long;
  logic [31:0]      tag_fnum;
  logic [2:0]       tag_wt;
  logic             len_big;
  logic [POS_W-1:0] len_sat;

  pwlw_varint u_varint (
    .byte_i     (in_i.data_byte),
    .cnt_i      (cnt_q),
    .acc_i      (acc_q),
    .hi_i       (hi_q),
    .acc_o      (vi_acc),
    .hi_o       (vi_hi),
    .more_o     (vi_more),
    .too_long_o (vi_too_long)
  );

  assign in_i.ready  = space;
  assign in_fire     = in_i.valid && space;
  assign load_result = in_fire && in_i.is_last;

  // The field number is tag bits 34..3, the wire type bits 2..0.
  assign tag_fnum = vi_acc[ACC_W-1:3];
  assign tag_wt   = vi_acc[2:0];

  // Lengths beyond the buffer bound saturate to it.
  assign len_big = vi_hi || (vi_acc > LEN_MAX);
  assign len_sat = len_big ? POS_MAX : vi_acc[POS_W-1:0];

  // Next state after taking the byte; bytes after a stop leave it alone.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    hi_d    = hi_q;
    skip_d  = skip_q;
    pos_d   = pos_q;
    bound_d = bound_q;
    stop_d  = stop_q;
    if (stop_q == STOP_NONE) begin
      pos_d = (pos_q < POS_MAX) ? pos_q + 1'b1 : POS_MAX;
      if (phase_q == PH_SKIP) begin
        skip_d = (skip_q != '0) ? skip_q - 1'b1 : skip_q;
        if (skip_d == '0) begin
          phase_d = PH_TAG;
          bound_d = pos_d;
        end
      end else begin
        acc_d = vi_acc;
        hi_d  = vi_hi;
        if (vi_more) begin
          if (vi_too_long) begin
            stop_d = STOP_VARINT_LONG;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          // The varint is complete: act on it and start a fresh one.
          acc_d = '0;
          hi_d  = 1'b0;
          cnt_d = '0;
          case (phase_q)
            PH_TAG: begin
              if (tag_fnum == '0) begin
                stop_d = STOP_ZERO_FIELD;
              end else if (tag_fnum > max_field_q) begin
                stop_d = STOP_OVER_LIMIT;
              end else begin
                case (tag_wt)
                  WT_VARINT: begin
                    phase_d = PH_VALUE;
                  end
                  WT_FIXED64: begin
                    skip_d  = SKIP_FIXED64;
                    phase_d = PH_SKIP;
                  end
                  WT_LENGTH: begin
                    phase_d = PH_LENGTH;
                  end
                  WT_FIXED32: begin
                    skip_d  = SKIP_FIXED32;
                    phase_d = PH_SKIP;
                  end
                  default: begin
                    stop_d = STOP_BAD_WIRE;
                  end
                endcase
              end
            end
            PH_VALUE: begin
              phase_d = PH_TAG;
              bound_d = pos_d;
            end
            default: begin
              // Length varint: an empty payload closes the field at once.
              if (len_sat == '0) begin
                phase_d = PH_TAG;
                bound_d = pos_d;
              end else begin
                skip_d  = len_sat;
                phase_d = PH_SKIP;
              end
            end
          endcase
        end
      end
    end
  end

  // A buffer that ends mid-field without another error is truncated.
  always_comb begin
    if (stop_d != STOP_NONE) begin
      reason = stop_d;
    end else if ((phase_d != PH_TAG) || (cnt_d != '0)) begin
      reason = STOP_TRUNCATED;
    end else begin
      reason = STOP_NONE;
    end
  end

  assign result.measured_size = SIZE_W'(bound_d);
  assign result.clean_end     = (reason == STOP_NONE);
  assign result.stop_reason   = reason;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_field_q <= MAX_FIELD_RESET;
    end else if (cfg_we_i) begin
      max_field_q <= cfg_wdata_i;
    end
  end

  // The last byte of a buffer returns the walker to its starting state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      cnt_q   <= '0;
      acc_q   <= '0;
      hi_q    <= 1'b0;
      skip_q  <= '0;
      pos_q   <= '0;
      bound_q <= '0;
      stop_q  <= STOP_NONE;
    end else if (in_fire) begin
      if (in_i.is_last) begin
        phase_q <= PH_TAG;
        cnt_q   <= '0;
        acc_q   <= '0;
        hi_q    <= 1'b0;
        skip_q  <= '0;
        pos_q   <= '0;
        bound_q <= '0;
        stop_q  <= STOP_NONE;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        acc_q   <= acc_d;
        hi_q    <= hi_d;
        skip_q  <= skip_d;
        pos_q   <= pos_d;
        bound_q <= bound_d;
        stop_q  <= stop_d;
      end
    end
  end

  pwlw_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load_result),
    .result_i (result),
    .space_o  (space),
    .out_o    (out_o)
  );

  // While skipping there is always at least one byte left to skip.
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (skip_q != '0))
    else $error("skip phase entered with nothing to skip");

  // The reported boundary never runs ahead of the byte position.
  a_bound_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bound_q <= pos_q)
    else $error("field boundary beyond byte position");

  // Taking the last byte leaves the walker cleared for the next buffer.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> (pos_q == '0) && (phase_q == PH_TAG) && (stop_q == STOP_NONE))
    else $error("walker not cleared after the last byte");

  // A delivered result is clean exactly when no stop reason is given.
  a_clean_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.clean_end == (out_o.stop_reason == STOP_NONE)))
    else $error("clean end flag disagrees with stop reason");

endmodule

FILE: sv/pwlw_varint.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlw_varint: varint byte accumulator
// Merges the seven payload bits of one byte into the running varint value.
// ----------------------------------------------------------------------------
module pwlw_varint
  import pwlw_pkg::*;
(
  input  logic [7:0]       byte_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  logic [ACC_W-1:0] acc_i,
  input  logic             hi_i,
  output logic [ACC_W-1:0] acc_o,
  output logic             hi_o,
  output logic             more_o,
  output logic             too_long_o
);

  logic [5:0]  shamt;
  logic [63:0] placed;

  // Each byte lands seven bits above the previous one; bits past 63 drop.
  assign shamt  = 6'(cnt_i) * 6'd7;
  assign placed = {57'd0, byte_i[6:0]} << shamt;

  assign acc_o      = acc_i | placed[ACC_W-1:0];
  assign hi_o       = hi_i | (|placed[63:ACC_W]);
  assign more_o     = byte_i[7];
  assign too_long_o = byte_i[7] && (cnt_i == VARINT_LAST_IDX);

endmodule

FILE: sv/pwlw_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwlw_out_reg: result output register
// Holds one result until the sink takes it and reports space upstream.
// ----------------------------------------------------------------------------
module pwlw_out_reg
  import pwlw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    result_i,
  output logic       space_o,
  pwlw_out_if.source out_o
);

  logic    valid_q;
  result_t res_q;

  // Space whenever the register is empty or being drained this cycle.
  assign space_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.measured_size = res_q.measured_size;
  assign out_o.clean_end     = res_q.clean_end;
  assign out_o.stop_reason   = res_q.stop_reason;

endmodule
